@@ sv/motor_current_foldback_ir_comp_assert.svh @@
// Assertion macros shared by the motor current foldback RTL.
`ifndef MOTOR_CURRENT_FOLDBACK_IR_COMP_ASSERT_SVH
`define MOTOR_CURRENT_FOLDBACK_IR_COMP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define MCF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define MCF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MCF_ASSERT_IMP(lbl, ante, cons)
`define MCF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ sv/mcf_pkg.sv @@
// Types and constants shared by the motor current foldback block.
`timescale 1ns / 1ps

package mcf_pkg;

	// back-EMF gain, Q8.8
	localparam logic [15:0] BACK_EMF_GAIN = 16'd256;
	// 0.5 V at 24 fraction bits
	localparam int HALF_VOLT_Q24 = 1 << 23;
	// 0.9 in Q1.15, truncated
	localparam int DUTY_BOUND = 29491;

	localparam int NUM_W = 35;
	localparam int DEN_W = 17;
	localparam int QUO_W = 17;
	localparam int DIV_STEPS = 17;
	localparam int CNT_W = 5;

	typedef enum logic [1:0] {
		MODE_NORMAL   = 2'd0,
		MODE_BOOST    = 2'd1,
		MODE_FOLDBACK = 2'd2
	} mode_t;

	// configuration register indexes
	typedef enum logic [3:0] {
		REG_FB_TRIP_CUR   = 4'd0,
		REG_FB_TRIP_TICKS = 4'd1,
		REG_FB_LIMIT      = 4'd2,
		REG_COOL_TICKS    = 4'd3,
		REG_BOOST_CUR     = 4'd4,
		REG_BOOST_TICKS   = 4'd5,
		REG_NORMAL_LIMIT  = 4'd6,
		REG_WINDING_RES   = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ sv/mcf_div.sv @@
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
`timescale 1ns / 1ps
`include "motor_current_foldback_ir_comp_assert.svh"

module mcf_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mcf_pkg::div_req_t         req,
	output mcf_pkg::div_stat_t        stat,
	output logic [mcf_pkg::QUO_W-1:0] quot
);

	logic                      busy_q;
	logic                      done_q;
	logic [mcf_pkg::CNT_W-1:0] cnt_q;
	logic [mcf_pkg::NUM_W-1:0] rem_q;
	logic [mcf_pkg::NUM_W-1:0] ds_q;
	logic [mcf_pkg::QUO_W-1:0] quo_q;
	logic                      ge;

	assign ge = (rem_q >= ds_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= mcf_pkg::CNT_W'(mcf_pkg::DIV_STEPS - 1);
			end
		end
	end

	// divisor starts at den << 16 and walks right one bit per step
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - ds_q;
			end
			quo_q <= {quo_q[mcf_pkg::QUO_W-2:0], ge};
			ds_q  <= ds_q >> 1;
		end else if (req.start) begin
			rem_q <= req.num;
			ds_q  <= mcf_pkg::NUM_W'({req.den, 16'd0});
			quo_q <= '0;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quo_q;

	`MCF_ASSERT_NXT(a_start_busy, req.start && !busy_q, busy_q)
	`MCF_ASSERT_IMP(a_cnt_range, busy_q, cnt_q <= mcf_pkg::CNT_W'(mcf_pkg::DIV_STEPS - 1))
	`MCF_ASSERT_IMP(a_done_idle, done_q, !busy_q && $past(busy_q))

endmodule

@@ sv/motor_current_foldback_ir_comp.sv @@
// Motor current foldback with IR compensation: protection state and duty computation.
`timescale 1ns / 1ps
`include "motor_current_foldback_ir_comp_assert.svh"

// One request per control tick: measured current, speed command and battery voltage.
// The protection state (normal/boost/foldback) updates at the accept edge; the
// duty then runs through a small sequencer that reuses one 18x18 multiplier three
// times (current limit times resistance, speed times gain, clamped current times
// resistance) and a restoring divider that yields one quotient bit per cycle.
// From accept to result valid a request passes 6 multiplier and add stages,
// 17 divider steps, a step to take the quotient and one to load the output
// register; with a zero battery voltage the divider steps are skipped.
// s_axis_tready stays low while a request is in work and comes back the
// cycle after the result is loaded, so a new request is taken only once the
// previous one has left the sequencer for the output register. A finished
// result sits in the output register until taken, and the next request is
// accepted meanwhile; that one then waits in the sequencer, with the input
// stalled, until the output register frees up. Config writes are taken at any
// time and must only be issued while the block is idle.
module motor_current_foldback_ir_comp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] measured_current, [31:16] speed_command, [47:32] battery_voltage
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] duty, [17:16] protect_mode, [32:18] active_limit, [39:33] zero
	output logic [39:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VMAX,
		ST_DES,
		ST_CLAMP,
		ST_IR,
		ST_SUM,
		ST_NUM,
		ST_DIV,
		ST_OUT
	} state_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// configuration
	logic [14:0] trip_cur_q;
	logic [15:0] trip_ticks_q;
	logic [14:0] fb_limit_q;
	logic [15:0] cool_ticks_q;
	logic [14:0] boost_cur_q;
	logic [15:0] boost_ticks_q;
	logic [14:0] normal_limit_q;
	logic [15:0] res_q;

	// protection state
	mcf_pkg::mode_t mode_q, mode_n;
	logic [14:0]    limit_q, limit_n;
	logic [15:0]    oc_q, oc_n;
	logic [15:0]    bc_q, bc_n;
	logic [15:0]    oc_inc, bc_inc;
	logic           tripped;
	logic signed [16:0] cur_in;
	logic [16:0]    mag;

	// sequencer
	state_t         state_q;
	logic           accept;
	logic           out_free;

	// datapath
	logic signed [15:0] cur_q;
	logic signed [15:0] spd_q;
	logic [15:0]        vb_q;
	logic signed [17:0] mul_a, mul_b;
	logic signed [35:0] prod_q;
	logic [30:0]        vmax_q;
	logic signed [40:0] desired;
	logic signed [40:0] vmax_ext;
	logic signed [40:0] vc_wide;
	logic signed [34:0] vclamp_q;
	logic signed [16:0] iapp_q;
	logic signed [16:0] iapp_n;
	logic signed [16:0] cur_ext;
	logic signed [16:0] lim_ext;
	logic signed [34:0] vt_q;
	logic               neg_q;
	logic [34:0]        vb_ext;
	logic [15:0]        duty_mag;
	logic [15:0]        duty_q;

	// output register
	logic [15:0]    out_duty_q;
	mcf_pkg::mode_t out_mode_q;
	logic [14:0]    out_limit_q;

	// divider
	mcf_pkg::div_req_t  div_req;
	mcf_pkg::div_stat_t div_stat;
	logic [mcf_pkg::QUO_W-1:0] div_quot;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trip_cur_q     <= 15'd15360;
			trip_ticks_q   <= 16'd2000;
			fb_limit_q     <= 15'd5120;
			cool_ticks_q   <= 16'd5000;
			boost_cur_q    <= 15'd12800;
			boost_ticks_q  <= 16'd3000;
			normal_limit_q <= 15'd10240;
			res_q          <= 16'd6554;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mcf_pkg::REG_FB_TRIP_CUR:   trip_cur_q     <= cfg_data[14:0];
				mcf_pkg::REG_FB_TRIP_TICKS: trip_ticks_q   <= cfg_data;
				mcf_pkg::REG_FB_LIMIT:      fb_limit_q     <= cfg_data[14:0];
				mcf_pkg::REG_COOL_TICKS:    cool_ticks_q   <= cfg_data;
				mcf_pkg::REG_BOOST_CUR:     boost_cur_q    <= cfg_data[14:0];
				mcf_pkg::REG_BOOST_TICKS:   boost_ticks_q  <= cfg_data;
				mcf_pkg::REG_NORMAL_LIMIT:  normal_limit_q <= cfg_data[14:0];
				mcf_pkg::REG_WINDING_RES:   res_q          <= cfg_data;
				default: ;
			endcase
		end
	end

	// protection update on the incoming current
	assign cur_in = {s_axis_tdata[15], s_axis_tdata[15:0]};
	assign mag    = cur_in[16] ? 17'(-cur_in) : 17'(cur_in);
	assign oc_inc = sat_inc(oc_q);
	assign bc_inc = sat_inc(bc_q);

	always_comb begin
		mode_n  = mode_q;
		limit_n = limit_q;
		oc_n    = oc_q;
		bc_n    = bc_q;
		tripped = 1'b0;
		if (mode_q != mcf_pkg::MODE_FOLDBACK) begin
			if (mag >= {2'b00, trip_cur_q}) begin
				if (oc_inc >= trip_ticks_q) begin
					tripped = 1'b1;
					mode_n  = mcf_pkg::MODE_FOLDBACK;
					limit_n = fb_limit_q;
					oc_n    = cool_ticks_q;
					bc_n    = '0;
				end else begin
					oc_n = oc_inc;
				end
			end else begin
				oc_n = '0;
			end
		end
		if (!tripped) begin
			unique case (mode_q)
				mcf_pkg::MODE_NORMAL: begin
					if (mag > {2'b00, boost_cur_q}) begin
						mode_n  = mcf_pkg::MODE_BOOST;
						bc_n    = '0;
						limit_n = boost_cur_q;
					end
				end
				mcf_pkg::MODE_BOOST: begin
					bc_n = bc_inc;
					if (bc_inc >= boost_ticks_q) begin
						mode_n  = mcf_pkg::MODE_NORMAL;
						limit_n = normal_limit_q;
					end
				end
				mcf_pkg::MODE_FOLDBACK: begin
					if (oc_q != '0) begin
						oc_n = oc_q - 16'd1;
					end else begin
						mode_n  = mcf_pkg::MODE_NORMAL;
						limit_n = normal_limit_q;
						bc_n    = '0;
					end
				end
				default: ;
			endcase
		end
	end

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_VMAX: begin
				mul_a = {3'b000, limit_q};
				mul_b = {2'b00, res_q};
			end
			ST_DES: begin
				mul_a = {{2{spd_q[15]}}, spd_q};
				mul_b = {2'b00, mcf_pkg::BACK_EMF_GAIN};
			end
			ST_IR: begin
				mul_a = {iapp_q[16], iapp_q};
				mul_b = {2'b00, res_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// clamp of the back-EMF demand and of the current
	assign desired  = {prod_q[32:0], 8'd0};
	assign vmax_ext = {10'd0, vmax_q};
	assign cur_ext  = {cur_q[15], cur_q};
	assign lim_ext  = {2'b00, limit_q};

	always_comb begin
		if (desired > 41'sd0) begin
			vc_wide = ((desired < vmax_ext) ? desired : vmax_ext)
				+ 41'(mcf_pkg::HALF_VOLT_Q24);
			iapp_n  = (cur_ext > lim_ext) ? lim_ext : cur_ext;
		end else if (desired < 41'sd0) begin
			vc_wide = ((desired > -vmax_ext) ? desired : -vmax_ext)
				- 41'(mcf_pkg::HALF_VOLT_Q24);
			iapp_n  = (cur_ext < -lim_ext) ? -lim_ext : cur_ext;
		end else begin
			vc_wide = '0;
			iapp_n  = '0;
		end
	end

	// divider request: numerator |vt| + vb, divisor 2 * vb (round to nearest)
	assign vb_ext      = {19'd0, vb_q};
	assign div_req.start = (state_q == ST_NUM) && (vb_q != '0);
	assign div_req.num = vt_q[34] ? (vb_ext - 35'(vt_q)) : (35'(vt_q) + vb_ext);
	assign div_req.den = {vb_q, 1'b0};

	assign duty_mag = (div_quot > mcf_pkg::QUO_W'(mcf_pkg::DUTY_BOUND))
		? 16'(mcf_pkg::DUTY_BOUND) : div_quot[15:0];

	mcf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.stat  (div_stat),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= mcf_pkg::MODE_NORMAL;
			limit_q       <= 15'd10240;
			oc_q          <= '0;
			bc_q          <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			// in ST_OUT a taken result is replaced below
			if (m_axis_tvalid && m_axis_tready && (state_q != ST_OUT)) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q  <= mode_n;
						limit_q <= limit_n;
						oc_q    <= oc_n;
						bc_q    <= bc_n;
						state_q <= ST_VMAX;
					end
				end
				ST_VMAX:  state_q <= ST_DES;
				ST_DES:   state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_IR;
				ST_IR:    state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_NUM;
				ST_NUM:   state_q <= (vb_q == '0) ? ST_OUT : ST_DIV;
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= s_axis_tdata[15:0];
			spd_q <= s_axis_tdata[31:16];
			vb_q  <= s_axis_tdata[47:32];
		end
		prod_q <= mul_a * mul_b;
		if (state_q == ST_DES) begin
			vmax_q <= prod_q[30:0];
		end
		if (state_q == ST_CLAMP) begin
			vclamp_q <= vc_wide[34:0];
			iapp_q   <= iapp_n;
		end
		if (state_q == ST_SUM) begin
			vt_q <= vclamp_q + prod_q[34:0];
		end
		if (state_q == ST_NUM) begin
			neg_q  <= vt_q[34];
			duty_q <= '0;
		end
		if (state_q == ST_DIV && div_stat.done) begin
			duty_q <= neg_q ? 16'(-duty_mag) : duty_mag;
		end
		if (state_q == ST_OUT && out_free) begin
			out_duty_q  <= duty_q;
			out_mode_q  <= mode_q;
			out_limit_q <= limit_q;
		end
	end

	assign m_axis_tdata = {7'd0, out_limit_q, out_mode_q, out_duty_q};

	`MCF_ASSERT_NXT(a_busy_after_accept, accept, !s_axis_tready)
	`MCF_ASSERT_NXT(a_state_held, !accept, $stable(mode_q) && $stable(limit_q) && $stable(oc_q))
	`MCF_ASSERT_IMP(a_result_src, $rose(m_axis_tvalid), $past(state_q == ST_OUT))
	`MCF_ASSERT_IMP(a_duty_bound, m_axis_tvalid,
		($signed(out_duty_q) <= 16'sd29491) && ($signed(out_duty_q) >= -16'sd29491))

endmodule
